@@ src/dstq_pkg.sv @@
// Shared types and constants of the deadline sorted timer queue.
// No dependencies; imported by the top level.
package dstq_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int DUE_W       = 48;
    localparam int ID_W        = 32;
    localparam int TAG_W       = 16;
    localparam int OP_W        = 3;
    localparam int POS_W       = 5;
    localparam int STAT_W      = 2;
    localparam int PEND_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_TAKE   = 3'd1,
        OP_CANCEL = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_LIST   = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ src/deadline_sorted_timer_queue_top.sv @@
// Top level of the deadline sorted timer queue: control sequencer and result port.
// Depends on dstq_pkg and dstq_ram.
//
// The queue is held in one RAM as a ring addressed from a head pointer; add, take,
// cancel and list walk it one entry per cycle via the RAM's single read and write
// port. Results come one per cycle, each for exactly one cycle under o_valid, and
// the run of an item ends with o_last; they cannot be held off. Clear, a refused
// add, a bad cancel position, an empty list and an unknown op answer at the edge
// after the item is taken. An add walks back from the tail, moving each held entry
// with a later due time one place up. A take scans the due entries from the head,
// up to MAX_RESULTS, then delivers and drops them (ST_NONE if none is due); a list
// delivers up to MAX_RESULTS entries. A cancel delivers the entry at position p and
// moves later ones down. busy stays high until the final result of the run is shown.
module deadline_sorted_timer_queue_top
    import dstq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DUE_W-1:0]  i_new_due,
    input  logic [TAG_W-1:0]  i_new_tag,
    input  logic [DUE_W-1:0]  i_now_time,
    input  logic [POS_W-1:0]  i_cancel_position,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_entry_id,
    output logic [DUE_W-1:0]  o_entry_due,
    output logic [TAG_W-1:0]  o_entry_tag,
    output logic [PEND_W-1:0] o_pending_count,
    output logic              o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CMP,
        S_ADD_PUT,
        S_SCAN,
        S_EMIT,
        S_CAN_GRAB,
        S_CAN_SHIFT
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_head, n_head;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_lim, n_lim;
    logic [CW-1:0]     r_pend, n_pend;
    logic              r_take, n_take;
    t_entry            r_new, n_new;
    t_entry            r_ent, n_ent;

    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    t_entry            r_out, n_out;
    logic [PEND_W-1:0] r_pend_out, n_pend_out;
    logic              r_last, n_last;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_bits;
    t_entry            rdata;

    logic              accept;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(idx);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    dstq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign rdata  = t_entry'(ram_rdata_bits);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        logic    emit;
        t_status e_status;
        t_entry  e_ent;
        logic [CW-1:0] e_pend;
        logic    e_last;

        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_next_id  = r_next_id;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_pend     = r_pend;
        n_take     = r_take;
        n_new      = r_new;
        n_ent      = r_ent;
        ram_we     = 1'b0;
        ram_waddr  = phys(r_head, r_idx);
        ram_wdata  = rdata;
        ram_raddr  = phys(r_head, r_idx);
        emit       = 1'b0;
        e_status   = ST_OK;
        e_ent      = '0;
        e_pend     = r_count;
        e_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_ADD: begin
                            if (r_count == CW'(DEPTH)) begin
                                emit     = 1'b1;
                                e_status = ST_FULL;
                            end else begin
                                n_new.due = i_new_due;
                                n_new.tag = i_new_tag;
                                n_new.id  = r_next_id;
                                n_next_id = r_next_id + ID_W'(1);
                                n_idx     = r_count;
                                if (r_count == '0) begin
                                    n_state = S_ADD_PUT;
                                end else begin
                                    ram_raddr = phys(r_head, r_count - CW'(1));
                                    n_state   = S_ADD_CMP;
                                end
                            end
                        end
                        OP_TAKE: begin
                            n_new.due = i_now_time;
                            n_idx     = '0;
                            ram_raddr = phys(r_head, '0);
                            n_state   = S_SCAN;
                        end
                        OP_CANCEL: begin
                            if (i_cancel_position == '0
                                    || int'(i_cancel_position) > int'(r_count)) begin
                                emit     = 1'b1;
                                e_status = ST_RANGE;
                            end else begin
                                n_idx     = CW'(i_cancel_position - POS_W'(1));
                                ram_raddr = phys(r_head,
                                                 CW'(i_cancel_position - POS_W'(1)));
                                n_state   = S_CAN_GRAB;
                            end
                        end
                        OP_CLEAR: begin
                            emit    = 1'b1;
                            n_count = '0;
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = ST_NONE;
                            end else begin
                                n_lim     = (int'(r_count) > MAX_RESULTS)
                                            ? CW'(MAX_RESULTS) : r_count;
                                n_pend    = r_count;
                                n_take    = 1'b0;
                                n_idx     = '0;
                                ram_raddr = phys(r_head, '0);
                                n_state   = S_EMIT;
                            end
                        end
                        default: begin
                            emit     = 1'b1;
                            e_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_ADD_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx);
                if (rdata.due > r_new.due) begin
                    ram_wdata = rdata;
                    n_idx     = r_idx - CW'(1);
                    if (r_idx == CW'(1)) begin
                        n_state = S_ADD_PUT;
                    end else begin
                        ram_raddr = phys(r_head, r_idx - CW'(2));
                    end
                end else begin
                    ram_wdata = r_new;
                    emit      = 1'b1;
                    e_ent     = r_new;
                    e_pend    = r_count + CW'(1);
                    n_count   = r_count + CW'(1);
                    n_state   = S_IDLE;
                end
            end
            S_ADD_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx);
                ram_wdata = r_new;
                emit      = 1'b1;
                e_ent     = r_new;
                e_pend    = r_count + CW'(1);
                n_count   = r_count + CW'(1);
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx < r_count && int'(r_idx) < MAX_RESULTS
                        && rdata.due <= r_new.due) begin
                    n_idx     = r_idx + CW'(1);
                    ram_raddr = phys(r_head, r_idx + CW'(1));
                end else if (r_idx == '0) begin
                    emit     = 1'b1;
                    e_status = ST_NONE;
                    n_state  = S_IDLE;
                end else begin
                    n_lim     = r_idx;
                    n_pend    = r_count - r_idx;
                    n_take    = 1'b1;
                    n_idx     = '0;
                    ram_raddr = phys(r_head, '0);
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                emit      = 1'b1;
                e_ent     = rdata;
                e_pend    = r_pend;
                e_last    = (r_idx + CW'(1) == r_lim);
                n_idx     = r_idx + CW'(1);
                ram_raddr = phys(r_head, r_idx + CW'(1));
                if (e_last) begin
                    n_state = S_IDLE;
                    if (r_take) begin
                        n_head  = phys(r_head, r_lim);
                        n_count = r_count - r_lim;
                    end
                end
            end
            S_CAN_GRAB: begin
                n_ent = rdata;
                if (r_idx + CW'(1) == r_count) begin
                    emit    = 1'b1;
                    e_ent   = rdata;
                    e_pend  = r_count - CW'(1);
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = phys(r_head, r_idx + CW'(1));
                    n_state   = S_CAN_SHIFT;
                end
            end
            S_CAN_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx);
                ram_wdata = rdata;
                if (r_idx + CW'(2) == r_count) begin
                    emit    = 1'b1;
                    e_ent   = r_ent;
                    e_pend  = r_count - CW'(1);
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_idx     = r_idx + CW'(1);
                    ram_raddr = phys(r_head, r_idx + CW'(2));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_valid    = emit;
        n_status   = emit ? e_status : r_status;
        n_out      = emit ? e_ent : r_out;
        n_pend_out = emit ? PEND_W'(e_pend) : r_pend_out;
        n_last     = emit ? e_last : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_next_id <= ID_W'(1);
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_next_id <= n_next_id;
            r_valid   <= n_valid;
        end
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_pend     <= n_pend;
        r_take     <= n_take;
        r_new      <= n_new;
        r_ent      <= n_ent;
        r_status   <= n_status;
        r_out      <= n_out;
        r_pend_out <= n_pend_out;
        r_last     <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_entry_id      = r_out.id;
    assign o_entry_due     = r_out.due;
    assign o_entry_tag     = r_out.tag;
    assign o_pending_count = r_pend_out;
    assign o_last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("held count exceeds depth");

    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("result run broken before its final item");

    a_idle_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !busy |-> o_last)
        else $error("block idle while a run is open");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy)
        else $error("RAM written while idle");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_CLEAR |=> r_count == '0 && o_valid && o_last)
        else $error("clear did not empty the queue");

endmodule

@@ src/dstq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
